@@ rtl/core/pte_pkg.sv @@
package pte_pkg;

  localparam logic [1:0] MAX_VLAN_TAGS = 2'd2;

  localparam logic [15:0] TPID_CTAG  = 16'h8100;
  localparam logic [15:0] TPID_STAG  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [6:0] ETH_TYPE_POS = 7'd12;
  localparam logic [6:0] ETH_HDR_LEN  = 7'd14;
  localparam logic [7:0] IP_HDR_LEN   = 8'd20;
  localparam logic [7:0] TCP_HDR_LEN  = 8'd20;
  localparam logic [7:0] UDP_HDR_LEN  = 8'd8;
  localparam logic [6:0] OFFSET_MAX   = 7'd127;

  // offsets inside the ipv4 header (and the l4 ports right after it)
  localparam logic [6:0] IP_OFF_PROTO    = 7'd9;
  localparam logic [6:0] IP_OFF_SRC      = 7'd12;
  localparam logic [6:0] IP_OFF_DST      = 7'd16;
  localparam logic [6:0] IP_OFF_PORTS    = 7'd20;
  localparam logic [6:0] IP_OFF_PORTS_HI = 7'd23;

  localparam logic [1:0] VERDICT_PASS    = 2'd0;
  localparam logic [1:0] VERDICT_DROP    = 2'd1;
  localparam logic [1:0] VERDICT_FORWARD = 2'd2;

  localparam logic REG_FORWARD_ENABLE = 1'b0;
  localparam logic REG_OUT_INTERFACE  = 1'b1;

  localparam int OUT_DATA_W = 144;

  typedef struct packed {
    logic [1:0]  verdict;
    logic        tuple_valid;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] forward_interface;
  } result_t;

endpackage

@@ rtl/core/pte_parse.sv @@
module pte_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic                 forward_enable,
  input  logic [31:0]          out_interface,
  output pte_pkg::result_t     res
);

  logic [6:0]  byte_offset;
  logic [15:0] ether_type;
  logic [1:0]  tag_count;
  logic [31:0] captured_src_ip;
  logic [31:0] captured_dst_ip;
  logic [7:0]  captured_protocol;
  logic [31:0] captured_ports;

  logic [6:0]  byte_offset_next;
  logic [15:0] ether_type_next;
  logic [1:0]  tag_count_next;
  logic [31:0] captured_src_ip_next;
  logic [31:0] captured_dst_ip_next;
  logic [7:0]  captured_protocol_next;
  logic [31:0] captured_ports_next;

  logic [6:0] type_pos;
  logic [6:0] l3_old;
  logic [6:0] off;
  logic [7:0] n;
  logic [7:0] l3;
  logic [7:0] ip_end;
  logic       good;
  logic [1:0] verdict;

  assign type_pos = pte_pkg::ETH_TYPE_POS + {3'b000, tag_count, 2'b00};
  assign l3_old   = pte_pkg::ETH_HDR_LEN + {3'b000, tag_count, 2'b00};
  assign off      = byte_offset - l3_old;

  always_comb begin
    ether_type_next        = ether_type;
    tag_count_next         = tag_count;
    captured_src_ip_next   = captured_src_ip;
    captured_dst_ip_next   = captured_dst_ip;
    captured_protocol_next = captured_protocol;
    captured_ports_next    = captured_ports;
    if (byte_offset == type_pos) begin
      ether_type_next = {data_byte, 8'h00};
    end else if (byte_offset == type_pos + 7'd1) begin
      ether_type_next = {ether_type[15:8], data_byte};
      // another tag: the real ethertype sits four bytes further on
      if ((ether_type_next == pte_pkg::TPID_CTAG || ether_type_next == pte_pkg::TPID_STAG)
          && tag_count < pte_pkg::MAX_VLAN_TAGS) begin
        tag_count_next = tag_count + 2'd1;
      end
    end else if (byte_offset >= l3_old) begin
      if (off == pte_pkg::IP_OFF_PROTO) begin
        captured_protocol_next = data_byte;
      end else if (off >= pte_pkg::IP_OFF_SRC && off < pte_pkg::IP_OFF_DST) begin
        captured_src_ip_next = {captured_src_ip[23:0], data_byte};
      end else if (off >= pte_pkg::IP_OFF_DST && off < pte_pkg::IP_OFF_PORTS) begin
        captured_dst_ip_next = {captured_dst_ip[23:0], data_byte};
      end else if (off >= pte_pkg::IP_OFF_PORTS && off <= pte_pkg::IP_OFF_PORTS_HI) begin
        captured_ports_next = {captured_ports[23:0], data_byte};
      end
    end
    byte_offset_next = (byte_offset < pte_pkg::OFFSET_MAX) ? byte_offset + 7'd1 : byte_offset;
  end

  // verdict from the state as it stands after this byte
  assign n      = {1'b0, byte_offset} + 8'd1;
  assign l3     = {1'b0, pte_pkg::ETH_HDR_LEN} + {4'b0000, tag_count_next, 2'b00};
  assign ip_end = l3 + pte_pkg::IP_HDR_LEN;

  always_comb begin
    good    = 1'b0;
    verdict = pte_pkg::VERDICT_DROP;
    if (n < l3) begin
      verdict = pte_pkg::VERDICT_DROP;
    end else if (ether_type_next != pte_pkg::ETYPE_IPV4) begin
      verdict = pte_pkg::VERDICT_PASS;
    end else if (n < ip_end) begin
      verdict = pte_pkg::VERDICT_DROP;
    end else if (captured_protocol_next == pte_pkg::PROTO_TCP) begin
      good = n >= ip_end + pte_pkg::TCP_HDR_LEN;
    end else if (captured_protocol_next == pte_pkg::PROTO_UDP) begin
      good = n >= ip_end + pte_pkg::UDP_HDR_LEN;
    end
    if (good && forward_enable) begin
      verdict = pte_pkg::VERDICT_FORWARD;
    end
  end

  always_comb begin
    res.verdict           = verdict;
    res.tuple_valid       = good;
    res.source_ip         = good ? captured_src_ip_next : 32'd0;
    res.dest_ip           = good ? captured_dst_ip_next : 32'd0;
    res.ip_protocol       = good ? captured_protocol_next : 8'd0;
    res.source_port       = good ? captured_ports_next[31:16] : 16'd0;
    res.dest_port         = good ? captured_ports_next[15:0] : 16'd0;
    res.forward_interface = (verdict == pte_pkg::VERDICT_FORWARD) ? out_interface : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      byte_offset       <= '0;
      ether_type        <= '0;
      tag_count         <= '0;
      captured_src_ip   <= '0;
      captured_dst_ip   <= '0;
      captured_protocol <= '0;
      captured_ports    <= '0;
    end else if (step) begin
      byte_offset       <= byte_offset_next;
      ether_type        <= ether_type_next;
      tag_count         <= tag_count_next;
      captured_src_ip   <= captured_src_ip_next;
      captured_dst_ip   <= captured_dst_ip_next;
      captured_protocol <= captured_protocol_next;
      captured_ports    <= captured_ports_next;
    end
  end

endmodule

@@ rtl/core/packet_five_tuple_extractor.sv @@
// result path: the last byte goes into the byte register, then its verdict into the
//   result register, where m_tvalid rises
// throughput: one byte per cycle; s_tready drops only while the byte register holds
//   a last byte and the previous verdict still waits in the output register
// reset (rst, synchronous): clears frame state and the output valid, forward_enable
//   goes to 1 and out_interface to 0
module packet_five_tuple_extractor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic                              s_tlast,   // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // verdict, tuple_valid, source_ip, dest_ip, ip_protocol, source_port,
  // dest_port, forward_interface, zero pad
  output logic [pte_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic        forward_enable;
  logic [31:0] out_interface;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        advance;
  logic        step;

  pte_pkg::result_t res;

  assign advance  = !s1_valid || !s1_last || !m_tvalid || m_tready;
  assign s_tready = advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_enable <= 1'b1;
      out_interface  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pte_pkg::REG_FORWARD_ENABLE: forward_enable <= cfg_data[0];
        pte_pkg::REG_OUT_INTERFACE:  out_interface  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  pte_parse u_parse (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .data_byte      (s1_byte),
    .last_byte      (s1_last),
    .forward_enable (forward_enable),
    .out_interface  (out_interface),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      m_tdata <= {5'b00000, res.forward_interface, res.dest_port, res.source_port,
                  res.ip_protocol, res.dest_ip, res.source_ip, res.tuple_valid, res.verdict};
    end
  end

endmodule

@@ rtl/core/pte_checker.sv @@
module pte_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pte_pkg::OUT_DATA_W-1:0] m_tdata
);

  // no result may be pending right out of reset
  a_reset_clears: assert property (@(posedge clk) $fell(rst) |-> !m_tvalid)
    else $error("result pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] == pte_pkg::VERDICT_PASS || m_tdata[1:0] == pte_pkg::VERDICT_DROP
                 || m_tdata[1:0] == pte_pkg::VERDICT_FORWARD)
    else $error("bad verdict code");

  // a forward needs a full tuple (in the design, only a forward also carries the interface)
  a_forward_tuple: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == pte_pkg::VERDICT_FORWARD |-> m_tdata[2])
    else $error("forward without tuple");

  a_tuple_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[106:3] == '0 && m_tdata[143:139] == '0)
    else $error("tuple fields set without tuple_valid");

endmodule

bind packet_five_tuple_extractor pte_checker u_pte_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
